@@ hw/rtl/sparse_fiber_vector_mac_macros.svh @@
// Assertion macros shared by the sparse fiber vector MAC modules.
`ifndef SPARSE_FIBER_VECTOR_MAC_MACROS_SVH
`define SPARSE_FIBER_VECTOR_MAC_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFVM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfvm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SFVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfvm assertion failed");

`endif

@@ hw/rtl/sfvm_pkg.sv @@
// Package with the constants and types of the sparse fiber vector MAC.
package sfvm_pkg;

	localparam int VEC_DEPTH   = 4096;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(VEC_DEPTH);
	localparam int POS_W       = 12;
	localparam int LEN_W       = 13;
	localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;
	localparam int SUM_W       = 64;
	localparam int PROD_W      = 2 * VALUE_WIDTH;
	localparam int IN_VALUE_W  = 32;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_TUSER_W = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MAC  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] prod;
		logic                    bad;
		logic                    last;
	} mac_entry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
		logic              full;
	} queue_status_t;

endpackage

@@ hw/rtl/sparse_fiber_vector_mac.sv @@
// Top level of the sparse fiber vector MAC: config register, front end, queue, back end.
// A fiber-last nonzero passes stage 1, stage 2, the queue and the result register before its result shows.
// Throughput: one item per cycle while the input is not stalled, set by the saturating accumulator loop.
// Output stalls hold back fiber-last nonzeros; with four nonzeros in flight the input stalls.
// Reset clears control state and the accumulator flags and sets vector_length to 4096.
// The vector store is not cleared: entries are undefined until loaded.
module sparse_fiber_vector_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sfvm_pkg::LEN_W-1:0]          cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// position [11:0], value [43:12], zero fill [47:44]
	input  logic [sfvm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// cmd [0]
	input  logic                                s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// fiber_sum [63:0]
	output logic [sfvm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// saturated [0], bad_position [1]
	output logic [sfvm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	logic [sfvm_pkg::LEN_W-1:0] vec_len_q;
	logic                       push;
	logic                       pop;
	sfvm_pkg::mac_entry_t       push_entry;
	sfvm_pkg::mac_entry_t       head;
	sfvm_pkg::queue_status_t    qstat;
	logic                       out_sat;
	logic                       out_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_len_q <= sfvm_pkg::LEN_RESET;
		end else if (cfg_we) begin
			vec_len_q <= cfg_wdata;
		end
	end

	sfvm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_len   (vec_len_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_pos    (s_axis_tdata[sfvm_pkg::POS_W-1:0]),
		.in_value  (s_axis_tdata[sfvm_pkg::POS_W +: sfvm_pkg::IN_VALUE_W]),
		.in_last   (s_axis_tlast),
		.qstat     (qstat),
		.push      (push),
		.push_entry(push_entry)
	);

	sfvm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.status    (qstat)
	);

	sfvm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(!qstat.empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sum   (m_axis_tdata),
		.out_sat   (out_sat),
		.out_bad   (out_bad)
	);

	assign m_axis_tuser = {out_bad, out_sat};

endmodule

@@ hw/rtl/sfvm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sfvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/sfvm_front.sv @@
// Front end: accepts items, writes or reads the vector store and forms products.
module sfvm_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [sfvm_pkg::LEN_W-1:0]             vec_len,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   in_cmd,
	input  logic [sfvm_pkg::POS_W-1:0]             in_pos,
	input  logic [sfvm_pkg::IN_VALUE_W-1:0]        in_value,
	input  logic                                   in_last,
	input  sfvm_pkg::queue_status_t                qstat,
	output logic                                   push,
	output sfvm_pkg::mac_entry_t                   push_entry
);

	logic                                   accept;
	logic                                   is_mac;
	logic                                   in_depth;
	logic                                   pos_ok;
	logic                                   ram_we;
	logic                                   ram_re;
	logic [sfvm_pkg::ADDR_W-1:0]            ram_addr;
	logic [sfvm_pkg::VALUE_WIDTH-1:0]       ram_rdata;
	logic signed [sfvm_pkg::PROD_W-1:0]     prod_full;

	logic                                   valid_s1;
	logic                                   bad_s1;
	logic                                   last_s1;
	logic [sfvm_pkg::VALUE_WIDTH-1:0]       value_s1;

	logic                                   valid_s2;
	logic                                   bad_s2;
	logic                                   last_s2;
	logic signed [sfvm_pkg::SUM_W-1:0]      prod_s2;

	assign in_ready = (32'(qstat.count) + 32'(valid_s1) + 32'(valid_s2))
		< 32'(sfvm_pkg::QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;
	assign is_mac   = accept && (in_cmd == sfvm_pkg::CMD_MAC);
	assign in_depth = 32'(in_pos) < 32'(sfvm_pkg::VEC_DEPTH);
	assign pos_ok   = in_depth && (32'(in_pos) < 32'(vec_len));
	assign ram_we   = accept && (in_cmd == sfvm_pkg::CMD_LOAD) && in_depth;
	assign ram_re   = is_mac && pos_ok;
	assign ram_addr = sfvm_pkg::ADDR_W'(in_pos);

	sfvm_ram #(
		.WIDTH(sfvm_pkg::VALUE_WIDTH),
		.DEPTH(sfvm_pkg::VEC_DEPTH)
	) u_vector_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(in_value[sfvm_pkg::VALUE_WIDTH-1:0]),
		.re   (ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= is_mac;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_mac) begin
			bad_s1   <= !pos_ok;
			last_s1  <= in_last;
			value_s1 <= in_value[sfvm_pkg::VALUE_WIDTH-1:0];
		end
	end

	assign prod_full = $signed(value_s1) * $signed(ram_rdata);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			bad_s2  <= bad_s1;
			last_s2 <= last_s1;
			prod_s2 <= bad_s1 ? '0 : sfvm_pkg::SUM_W'(prod_full);
		end
	end

	assign push            = valid_s2;
	assign push_entry.prod = prod_s2;
	assign push_entry.bad  = bad_s2;
	assign push_entry.last = last_s2;

endmodule

@@ hw/rtl/sfvm_queue.sv @@
// Short queue of products between the front end and the accumulator.
`include "sparse_fiber_vector_mac_macros.svh"

module sfvm_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  sfvm_pkg::mac_entry_t    push_entry,
	input  logic                    pop,
	output sfvm_pkg::mac_entry_t    head,
	output sfvm_pkg::queue_status_t status
);

	sfvm_pkg::mac_entry_t            mem_q [sfvm_pkg::QUEUE_DEPTH];
	logic [sfvm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [sfvm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [sfvm_pkg::QCNT_W-1:0]     count_q;

	function automatic logic [sfvm_pkg::QPTR_W-1:0] next_ptr(
		input logic [sfvm_pkg::QPTR_W-1:0] ptr
	);
		if (ptr == sfvm_pkg::QPTR_W'(sfvm_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + sfvm_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + sfvm_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - sfvm_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == sfvm_pkg::QCNT_W'(sfvm_pkg::QUEUE_DEPTH));

	`SFVM_ASSERT_SAME(a_no_overflow, clk, arst_n, push && status.full, pop)
	`SFVM_ASSERT_SAME(a_no_underflow, clk, arst_n, pop, !status.empty)

endmodule

@@ hw/rtl/sfvm_back.sv @@
// Back end: saturating fiber accumulator and result register.
`include "sparse_fiber_vector_mac_macros.svh"

module sfvm_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sfvm_pkg::mac_entry_t               head,
	input  logic                               head_valid,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sfvm_pkg::SUM_W-1:0]         out_sum,
	output logic                               out_sat,
	output logic                               out_bad
);

	logic [sfvm_pkg::SUM_W-1:0] sum_q;
	logic                       sat_q;
	logic                       bad_q;
	logic                       out_valid_q;
	logic [sfvm_pkg::SUM_W-1:0] sum_raw;
	logic                       ovf;
	logic [sfvm_pkg::SUM_W-1:0] sum_next;
	logic                       sat_next;
	logic                       bad_next;

	assign pop = head_valid && (!head.last || !out_valid_q || out_ready);

	always_comb begin
		sum_raw = sum_q + head.prod;
		ovf     = (sum_q[sfvm_pkg::SUM_W-1] == head.prod[sfvm_pkg::SUM_W-1])
			&& (sum_raw[sfvm_pkg::SUM_W-1] != sum_q[sfvm_pkg::SUM_W-1]);
		if (ovf) begin
			sum_next = head.prod[sfvm_pkg::SUM_W-1]
				? {1'b1, {(sfvm_pkg::SUM_W - 1){1'b0}}}
				: {1'b0, {(sfvm_pkg::SUM_W - 1){1'b1}}};
		end else begin
			sum_next = sum_raw;
		end
		sat_next = sat_q || ovf;
		bad_next = bad_q || head.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			sat_q       <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.last) begin
				sum_q       <= '0;
				sat_q       <= 1'b0;
				bad_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					sum_q <= sum_next;
					sat_q <= sat_next;
					bad_q <= bad_next;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			out_sum <= sum_next;
			out_sat <= sat_next;
			out_bad <= bad_next;
		end
	end

	assign out_valid = out_valid_q;

	`SFVM_ASSERT_NEXT(a_emit_on_last, clk, arst_n, pop && head.last, out_valid_q)
	`SFVM_ASSERT_NEXT(a_clear_after_last, clk, arst_n, pop && head.last,
		(sum_q == '0) && !sat_q && !bad_q)

endmodule
